FILE: rtl/uofp_pkg.sv
// Package for the radio API receive frame parser with OSC payload decoding.
// Holds the parse phase and status types, register indexes and character constants.
// No dependencies.
package uofp_pkg;

    typedef enum logic [3:0] {
        PH_WAIT    = 4'd0,
        PH_LEN     = 4'd1,
        PH_TYPE    = 4'd2,
        PH_IP      = 4'd3,
        PH_DPORT   = 4'd4,
        PH_SPORT   = 4'd5,
        PH_PROTO   = 4'd6,
        PH_STAT    = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_CKSUM   = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SLASH  = 3'd1,
        ST_NO_T      = 3'd2,
        ST_NO_SLASH2 = 3'd3,
        ST_MALFORMED = 3'd4,
        ST_TOO_SHORT = 3'd5
    } t_status;

    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELIM = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE  = 8'd1;

    localparam logic [7:0] START_DELIM_RST = 8'd126;
    localparam logic [7:0] FRAME_TYPE_RST  = 8'd176;

    localparam logic [15:0] HDR_OVERHEAD = 16'd11;
    localparam int unsigned HEAD_DEPTH   = 16;
    localparam int unsigned HEAD_IDX_W   = $clog2(HEAD_DEPTH);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam int unsigned OUT_W = 128;

endpackage

FILE: rtl/udp_osc_frame_parser_unit.sv
// Top level of the radio API receive frame parser with OSC payload decoding.
// Uses uofp_pkg for types and constants; instantiates no other module.
//
// The block takes one received byte per item and can accept a byte in every
// clock cycle. Each byte updates the frame state in a single registered step.
// When the checksum byte of a well-formed header is accepted, one result item
// appears on the output in the next cycle and sits in an output register until
// taken; meanwhile further bytes are accepted, and only a following checksum
// byte waits for that register to drain. Frames with a header mismatch are
// dropped without a result. Configuration writes take effect at once.
module udp_osc_frame_parser_unit
    import uofp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // in_byte [7:0]
    input  logic [7:0]           s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status [2:0], source_ip [34:3], dest_port [50:35], src_port [66:51],
    // command_code [74:67], set_get [82:75], type_tag [90:83],
    // value_word [122:91], zero fill [127:123]
    output logic [OUT_W-1:0]     m_axis_tdata
);

    logic [7:0]  r_start_delim;
    logic [7:0]  r_frame_type;
    t_phase      r_phase, n_phase;
    logic [15:0] r_byte_idx, n_byte_idx;
    logic [15:0] r_frame_len, n_frame_len;
    logic [15:0] r_pay_len, n_pay_len;
    logic [31:0] r_ip, n_ip;
    logic [15:0] r_dport, n_dport;
    logic [15:0] r_sport, n_sport;
    logic [7:0]  r_head [HEAD_DEPTH];
    logic        r_m_valid;
    logic [OUT_W-1:0] r_m_data, n_m_data;

    logic        s_acc;
    logic        head_we;
    logic [16:0] idx_inc;
    t_status     dec_status;
    logic [7:0]  b;

    assign b     = s_axis_tdata;
    assign s_axis_tready = (r_phase != PH_CKSUM) || !r_m_valid || m_axis_tready;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign idx_inc = {1'b0, r_byte_idx} + 17'd1;

    always_comb begin
        n_phase     = r_phase;
        n_byte_idx  = r_byte_idx;
        n_frame_len = r_frame_len;
        n_pay_len   = r_pay_len;
        n_ip        = r_ip;
        n_dport     = r_dport;
        n_sport     = r_sport;
        head_we     = 1'b0;
        unique case (r_phase)
            PH_WAIT: begin
                if (b == r_start_delim) begin
                    n_phase     = PH_LEN;
                    n_byte_idx  = '0;
                    n_frame_len = '0;
                    n_ip        = '0;
                end
            end
            PH_LEN: begin
                n_frame_len = {r_frame_len[7:0], b};
                if (r_byte_idx == 16'd0) begin
                    n_byte_idx = 16'd1;
                end else begin
                    n_byte_idx = '0;
                    n_phase    = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_byte_idx = '0;
                n_phase    = (b == r_frame_type) ? PH_IP : PH_WAIT;
            end
            PH_IP: begin
                n_ip = {r_ip[23:0], b};
                if (idx_inc >= 17'd4) begin
                    n_byte_idx = '0;
                    n_phase    = PH_DPORT;
                end else begin
                    n_byte_idx = idx_inc[15:0];
                end
            end
            PH_DPORT: begin
                n_dport = {r_dport[7:0], b};
                if (r_byte_idx == 16'd0) begin
                    n_byte_idx = 16'd1;
                end else begin
                    n_byte_idx = '0;
                    n_phase    = PH_SPORT;
                end
            end
            PH_SPORT: begin
                n_sport = {r_sport[7:0], b};
                if (r_byte_idx == 16'd0) begin
                    n_byte_idx = 16'd1;
                end else begin
                    n_byte_idx = '0;
                    n_phase    = PH_PROTO;
                end
            end
            PH_PROTO: begin
                if (b == 8'd0) begin
                    n_phase = PH_STAT;
                end else begin
                    n_phase    = PH_WAIT;
                    n_byte_idx = '0;
                end
            end
            PH_STAT: begin
                n_byte_idx = '0;
                if (b != 8'd0) begin
                    n_phase = PH_WAIT;
                end else if (r_frame_len < HDR_OVERHEAD + 16'd1) begin
                    n_pay_len = '0;
                    n_phase   = PH_CKSUM;
                end else begin
                    n_pay_len = r_frame_len - HDR_OVERHEAD;
                    n_phase   = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                head_we = (r_byte_idx[15:HEAD_IDX_W] == '0);
                if (idx_inc >= {1'b0, r_pay_len}) begin
                    n_byte_idx = '0;
                    n_phase    = PH_CKSUM;
                end else begin
                    n_byte_idx = idx_inc[15:0];
                end
            end
            PH_CKSUM: begin
                n_byte_idx = '0;
                n_phase    = PH_WAIT;
            end
            default: begin
                n_byte_idx = '0;
                n_phase    = PH_WAIT;
            end
        endcase
    end

    always_comb begin
        if (r_pay_len < 16'(HEAD_DEPTH)) begin
            dec_status = ST_TOO_SHORT;
        end else if (r_head[0] != CH_SLASH) begin
            dec_status = ST_NO_SLASH;
        end else if (r_head[1] != CH_T) begin
            dec_status = ST_NO_T;
        end else if (r_head[2] != CH_SLASH) begin
            dec_status = ST_NO_SLASH2;
        end else if (r_head[5] != 8'd0 || r_head[6] != 8'd0 || r_head[7] != 8'd0
                     || r_head[8] != CH_COMMA || r_head[10] != 8'd0
                     || r_head[11] != 8'd0) begin
            dec_status = ST_MALFORMED;
        end else begin
            dec_status = ST_OK;
        end
    end

    always_comb begin
        n_m_data        = '0;
        n_m_data[2:0]   = dec_status;
        n_m_data[34:3]  = r_ip;
        n_m_data[50:35] = r_dport;
        n_m_data[66:51] = r_sport;
        if (dec_status == ST_OK) begin
            n_m_data[74:67]  = r_head[3];
            n_m_data[82:75]  = r_head[4];
            n_m_data[90:83]  = r_head[9];
            n_m_data[122:91] = {r_head[12], r_head[13], r_head[14], r_head[15]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= START_DELIM_RST;
            r_frame_type  <= FRAME_TYPE_RST;
            r_phase       <= PH_WAIT;
            r_byte_idx    <= '0;
            r_frame_len   <= '0;
            r_pay_len     <= '0;
            r_ip          <= '0;
            r_dport       <= '0;
            r_sport       <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_START_DELIM) begin
                r_start_delim <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_FRAME_TYPE) begin
                r_frame_type <= i_cfg_data;
            end
            if (s_acc) begin
                r_phase     <= n_phase;
                r_byte_idx  <= n_byte_idx;
                r_frame_len <= n_frame_len;
                r_pay_len   <= n_pay_len;
                r_ip        <= n_ip;
                r_dport     <= n_dport;
                r_sport     <= n_sport;
            end
            if (s_acc && r_phase == PH_CKSUM) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && head_we) begin
            r_head[r_byte_idx[HEAD_IDX_W-1:0]] <= b;
        end
        if (s_acc && r_phase == PH_CKSUM) begin
            r_m_data <= n_m_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_result_follows_cksum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_phase == PH_CKSUM) |=> (r_m_valid && r_phase == PH_WAIT))
        else $error("checksum byte did not produce a result");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(s_acc && r_phase == PH_CKSUM))
        else $error("result appeared without a checksum byte");

    a_payload_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_byte_idx < r_pay_len))
        else $error("payload index ran past the payload length");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_data[2:0] <= 3'd5))
        else $error("result status out of range");

endmodule
